// ===== rtl/kdec_pkg.sv =====
// Shared constants, types and the key character table of the keypad digit entry collector.
`default_nettype none
package kdec_pkg;

  localparam int KEY_N          = 12;
  localparam int KIDX_W         = 4;
  localparam int CH_W           = 7;
  localparam int POS_W          = 4;
  localparam int DIG_W          = 4;
  localparam int MAX_DIGITS_DEF = 12;

  localparam logic [CH_W-1:0] CH_NONE = 7'h00;
  localparam logic [CH_W-1:0] CH_STAR = 7'h2A;
  localparam logic [CH_W-1:0] CH_HASH = 7'h23;
  localparam logic [CH_W-1:0] CH_ZERO = 7'h30;

  localparam logic [KIDX_W-1:0] KIDX_LAST = KIDX_W'(KEY_N - 1);

  typedef struct packed {
    logic              done;
    logic              found;
    logic [KIDX_W-1:0] idx;
  } scan_res_t;

  function automatic logic [CH_W-1:0] key_char(input logic [KIDX_W-1:0] idx);
    logic [CH_W-1:0] c;
    case (idx)
      4'd0:    c = CH_STAR;
      4'd1:    c = 7'h33;
      4'd2:    c = 7'h32;
      4'd3:    c = 7'h31;
      4'd4:    c = 7'h30;
      4'd5:    c = 7'h36;
      4'd6:    c = 7'h35;
      4'd7:    c = 7'h34;
      4'd8:    c = 7'h37;
      4'd9:    c = 7'h38;
      4'd10:   c = 7'h39;
      4'd11:   c = CH_HASH;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/kdec_scan.sv =====
// Bit-serial priority scanner that finds the lowest set key bit, one bit per cycle.
`default_nettype none
module kdec_scan (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic                        detect_i,
  input  wire logic [kdec_pkg::KEY_N-1:0]  key_bits_i,
  output kdec_pkg::scan_res_t              res_o
);
  import kdec_pkg::*;

  logic [KEY_N-1:0]  sh_q;
  logic [KIDX_W-1:0] idx_q;
  logic              run_q;
  logic              found_q;
  logic              done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
      idx_q   <= '0;
      sh_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        sh_q    <= detect_i ? key_bits_i : '0;
        idx_q   <= '0;
        run_q   <= 1'b1;
        found_q <= 1'b0;
      end else if (run_q) begin
        if (sh_q[0]) begin
          found_q <= 1'b1;
          run_q   <= 1'b0;
          done_q  <= 1'b1;
        end else if (idx_q == KIDX_LAST) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          sh_q  <= {1'b0, sh_q[KEY_N-1:1]};
          idx_q <= idx_q + KIDX_W'(1);
        end
      end
    end
  end

  assign res_o.done  = done_q;
  assign res_o.found = found_q;
  assign res_o.idx   = idx_q;

endmodule
`default_nettype wire

// ===== rtl/kdec_store.sv =====
// Digit entry buffer memory with one write port and one registered read port.
`default_nettype none
module kdec_store #(
  parameter int DEPTH = kdec_pkg::MAX_DIGITS_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [IDX_W-1:0]           waddr_i,
  input  wire logic [kdec_pkg::DIG_W-1:0] wdata_i,
  input  wire logic                       re_i,
  input  wire logic [IDX_W-1:0]           raddr_i,
  output logic      [kdec_pkg::DIG_W-1:0] rdata_o
);
  import kdec_pkg::*;

  logic [DIG_W-1:0] mem [DEPTH];
  logic [DIG_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/keypad_digit_entry_collector.sv =====
// Top level of the keypad digit entry collector: sequencer, entry count and output register.
// Usage:
//   The input channel takes one touch-change item (detect_i, key_bits_i) at an edge with
//   in_valid_i high and in_stall_o low. A serial scanner tests one key bit per cycle,
//   lowest bit first. A star, digit or empty item gives one key report (kind 0, last 1);
//   digits are kept in the entry buffer. A hash item gives one kind 1 result per stored
//   digit, each read from the buffer, then a terminator with last set. A full entry holds
//   eleven digits. in_stall_o stays high until the item's last result has been loaded
//   into the output register.
//   Results leave through a single output register: out_valid_o holds with its fields
//   while out_stall_i is high, and the sequencer waits for the register to free up.
//   A new item may be accepted while the final result still waits in that register.
//   Reset clears the sequencer, the digit count and the output valid; buffer contents
//   are not cleared, since only entries below the count are ever read.
`default_nettype none
module keypad_digit_entry_collector #(
  parameter int MAX_DIGITS = kdec_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        detect_i,
  input  wire logic [kdec_pkg::KEY_N-1:0]  key_bits_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             kind_o,
  output logic      [kdec_pkg::CH_W-1:0]   char_code_o,
  output logic      [kdec_pkg::POS_W-1:0]  position_o,
  output logic                             last_o
);
  import kdec_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIGITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_HRD   = 3'd3;
  localparam logic [2:0] S_HEMIT = 3'd4;
  localparam logic [2:0] S_HTERM = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [POS_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] cnt_inc;
  logic [POS_W-1:0] pos_inc;

  logic             out_valid_q;
  logic             kind_q;
  logic [CH_W-1:0]  char_q;
  logic [POS_W-1:0] position_q;
  logic             last_q;

  logic             ld;
  logic             ld_kind;
  logic [CH_W-1:0]  ld_char;
  logic [POS_W-1:0] ld_pos;
  logic             ld_last;
  logic             out_free;

  logic             in_acc;
  scan_res_t        scan;
  logic [CH_W-1:0]  ch;
  logic             st_we;
  logic             st_re;
  logic [DIG_W-1:0] st_wdata;
  logic [DIG_W-1:0] st_rdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign ch         = scan.found ? key_char(scan.idx) : CH_NONE;
  assign cnt_inc    = cnt_q + POS_W'(1);
  assign pos_inc    = pos_q + POS_W'(1);
  assign st_wdata   = DIG_W'(ch - CH_ZERO);

  kdec_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .detect_i   (detect_i),
    .key_bits_i (key_bits_i),
    .res_o      (scan)
  );

  kdec_store #(
    .DEPTH (MAX_DIGITS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (pos_q[IDX_W-1:0]),
    .rdata_o (st_rdata)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    ld      = 1'b0;
    ld_kind = 1'b0;
    ld_char = CH_NONE;
    ld_pos  = '0;
    ld_last = 1'b0;
    st_we   = 1'b0;
    st_re   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan.done) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (ch == CH_HASH) begin
          pos_d   = '0;
          state_d = (cnt_q == '0) ? S_HTERM : S_HRD;
        end else if (out_free) begin
          ld      = 1'b1;
          ld_char = ch;
          ld_last = 1'b1;
          state_d = S_IDLE;
          if (ch == CH_STAR) begin
            cnt_d = '0;
          end else if (ch != CH_NONE) begin
            st_we = 1'b1;
            cnt_d = (cnt_inc == POS_W'(MAX_DIGITS)) ? '0 : cnt_inc;
          end
        end
      end
      S_HRD: begin
        st_re   = 1'b1;
        state_d = S_HEMIT;
      end
      S_HEMIT: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_kind = 1'b1;
          ld_char = CH_ZERO + CH_W'(st_rdata);
          ld_pos  = pos_q;
          pos_d   = pos_inc;
          state_d = (pos_inc == cnt_q) ? S_HTERM : S_HRD;
        end
      end
      S_HTERM: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_kind = 1'b1;
          ld_pos  = cnt_q;
          ld_last = 1'b1;
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      if (ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      kind_q     <= ld_kind;
      char_q     <= ld_char;
      position_q <= ld_pos;
      last_q     <= ld_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign char_code_o = char_q;
  assign position_o  = position_q;
  assign last_o      = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan.done |-> (state_q == S_SCAN))
    else $error("Scanner finished outside the scan state.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < POS_W'(MAX_DIGITS))
    else $error("Digit count reached the entry capacity.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HEMIT) |-> (pos_q < cnt_q))
    else $error("Digit read beyond the stored entry.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !kind_o) |-> last_o)
    else $error("Key report without last set.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld |-> out_free)
    else $error("Output register overwritten while a result waits.");

endmodule
`default_nettype wire

// ===== test/tb_keypad_digit_entry_collector.sv =====
// Self-checking testbench for the keypad digit entry collector with a predicting scoreboard.
module tb_keypad_digit_entry_collector;
  import kdec_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int KEY_TARGET  = 380;

  // Character of each key line, lowest line first.
  localparam logic [CH_W-1:0] KEY_CHAR [KEY_N] = '{
    CH_STAR, 7'h33, 7'h32, 7'h31, 7'h30, 7'h36, 7'h35, 7'h34, 7'h37, 7'h38, 7'h39, CH_HASH
  };

  typedef struct packed {
    logic             kind;
    logic [CH_W-1:0]  char_code;
    logic [POS_W-1:0] position;
    logic             last;
  } key_report_t;

  class entry_scoreboard;
    key_report_t      awaited_reports[$];
    logic [DIG_W-1:0] entry_digits[16];
    int unsigned      entry_len;
    int unsigned      failures;
    int unsigned      reports_checked;
    int unsigned      entries_closed;
    int unsigned      entries_dropped;

    function new();
      entry_len       = 0;
      failures        = 0;
      reports_checked = 0;
      entries_closed  = 0;
      entries_dropped = 0;
    endfunction

    function logic [CH_W-1:0] decode_key(logic det, logic [KEY_N-1:0] kb);
      if (!det) return CH_NONE;
      for (int b = 0; b < KEY_N; b++) begin
        if (kb[b]) return KEY_CHAR[b];
      end
      return CH_NONE;
    endfunction

    function int unsigned pending();
      return awaited_reports.size();
    endfunction

    function void note_item(logic det, logic [KEY_N-1:0] kb);
      logic [CH_W-1:0] ch;
      ch = decode_key(det, kb);
      if (ch == CH_HASH) begin
        for (int unsigned i = 0; i < entry_len; i++) begin
          awaited_reports.push_back('{1'b1, CH_ZERO + CH_W'(entry_digits[i]), POS_W'(i), 1'b0});
        end
        awaited_reports.push_back('{1'b1, CH_NONE, POS_W'(entry_len), 1'b1});
        entry_len = 0;
        entries_closed++;
        return;
      end
      if (ch == CH_STAR) begin
        entry_len = 0;
      end else if (ch != CH_NONE) begin
        entry_digits[entry_len] = DIG_W'(ch - CH_ZERO);
        entry_len++;
        if (entry_len == MAX_DIGITS_DEF) begin
          entry_len = 0;
          entries_dropped++;
        end
      end
      awaited_reports.push_back('{1'b0, ch, {POS_W{1'b0}}, 1'b1});
    endfunction

    function void check_report(key_report_t got);
      key_report_t want;
      if (awaited_reports.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: kind=%0d char=%h pos=%0d last=%0d",
                   got.kind, got.char_code, got.position, got.last);
        return;
      end
      want = awaited_reports.pop_front();
      reports_checked++;
      if (got !== want) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: expected kind=%0d char=%h pos=%0d last=%0d",
                   want.kind, want.char_code, want.position, want.last);
          $display("          got      kind=%0d char=%h pos=%0d last=%0d",
                   got.kind, got.char_code, got.position, got.last);
        end
      end
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              detect    = 1'b0;
  logic [KEY_N-1:0]  key_bits  = '0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic              kind;
  logic [CH_W-1:0]   char_code;
  logic [POS_W-1:0]  position;
  logic              last_flag;

  entry_scoreboard   board;
  int unsigned       keys_sent = 0;
  logic              no_idle   = 1'b0;
  int unsigned       cycles    = 0;

  keypad_digit_entry_collector i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .detect_i    (detect),
    .key_bits_i  (key_bits),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .char_code_o (char_code),
    .position_o  (position),
    .last_o      (last_flag)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL keypad_digit_entry_collector");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall)
        board.check_report('{kind, char_code, position, last_flag});
      out_stall <= !no_idle && ($urandom_range(0, 99) < 28);
    end
  end

  task automatic send_item(input logic det, input logic [KEY_N-1:0] kb);
    while (!no_idle && ($urandom_range(0, 99) < 28)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    detect   <= det;
    key_bits <= kb;
    do @(posedge clk); while (in_stall);
    board.note_item(det, kb);
    keys_sent++;
    no_idle <= (keys_sent >= 150) && (keys_sent < 230);
  endtask

  initial begin
    int          len;
    int          pick;
    int          b;
    logic [KEY_N-1:0] kb;
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty events, a hash on an empty entry, every digit key, then a long entry and one cleared by star.
    send_item(1'b0, 12'hFFF);
    send_item(1'b1, 12'h000);
    send_item(1'b1, 12'h800);
    for (b = 1; b <= 10; b++) send_item(1'b1, KEY_N'(1 << b));
    send_item(1'b0, 12'h5A5);
    send_item(1'b1, 12'h802);
    send_item(1'b1, 12'h800);
    send_item(1'b1, 12'hFFF);
    send_item(1'b1, 12'h010);
    send_item(1'b1, 12'h400);
    send_item(1'b1, 12'h001);
    send_item(1'b1, 12'h800);

    // Mostly complete entries with random digits; the rest is random noise.
    while (keys_sent < KEY_TARGET) begin
      if ($urandom_range(0, 99) < 75) begin
        len = $urandom_range(0, 13);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0)
            send_item($urandom_range(0, 1) == 0 ? 1'b0 : 1'b1,
                      ($urandom_range(0, 1) == 0) ? '0 : KEY_N'($urandom));
          b  = $urandom_range(1, 10);
          kb = KEY_N'($urandom) & ~KEY_N'((1 << (b + 1)) - 1);
          send_item(1'b1, kb | KEY_N'(1 << b));
        end
        pick = $urandom_range(0, 99);
        if (pick < 85)
          send_item(1'b1, 12'h800);
        else
          send_item(1'b1, KEY_N'($urandom) | 12'h001);
      end else begin
        send_item(1'($urandom_range(0, 1)), KEY_N'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d items; %0d entries closed by hash, %0d dropped at capacity.",
             keys_sent, board.entries_closed, board.entries_dropped);
    $display("Checked %0d results, %0d failures.", board.reports_checked, board.failures);
    if (board.failures == 0) begin
      $display("PASS keypad_digit_entry_collector");
    end else begin
      $display("FAIL keypad_digit_entry_collector");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/kdec_pkg.sv
rtl/kdec_scan.sv
rtl/kdec_store.sv
rtl/keypad_digit_entry_collector.sv
test/tb_keypad_digit_entry_collector.sv
